// ----- rtl/kpaq_pkg.sv -----
// kpaq_pkg: shared types, constants and field layout for the key press
// autorepeat queue; used by every module of the block but kpaq_ram, depends on nothing
`default_nettype none
package kpaq_pkg;

  // key scan shape
  localparam int MAX_KEYS = 6;
  localparam int KEY_W    = 8;
  localparam int CNT_W    = 3;
  localparam int KEY_CW   = $clog2(MAX_KEYS + 1);
  localparam int KEY_IW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NOW_W    = 32;
  localparam int CFG_W    = 16;

  // input tdata layout
  localparam int CNT_LSB   = MAX_KEYS * KEY_W;
  localparam int FN_BIT    = CNT_LSB + CNT_W;
  localparam int CTRL_BIT  = FN_BIT + 1;
  localparam int ALT_BIT   = FN_BIT + 2;
  localparam int SHIFT_BIT = FN_BIT + 3;
  localparam int NOW_LSB   = FN_BIT + 4;
  localparam int IN_BITS   = NOW_LSB + NOW_W;
  localparam int IN_DW     = ((IN_BITS + 7) / 8) * 8;

  // event ring
  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  // command queue between front and back
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  // configuration registers
  localparam int  CFG_DW    = 32;
  localparam int  CFG_AW    = 3;
  localparam logic REG_INIT_DELAY  = 1'b0;
  localparam logic REG_REPEAT_IVAL = 1'b1;
  localparam logic [CFG_W-1:0] INIT_DELAY_RST  = 16'd450;
  localparam logic [CFG_W-1:0] REPEAT_IVAL_RST = 16'd65;

  typedef struct packed {
    logic shift;
    logic alt;
    logic ctrl;
    logic fn;
  } mods_t;

  // ring entry: [7:0] key, 8 fn, 9 ctrl, 10 alt, 11 shift, 12 repeat
  typedef struct packed {
    logic             rep;
    mods_t            mods;
    logic [KEY_W-1:0] key;
  } evt_t;

  localparam int EVT_W  = $bits(evt_t);
  localparam int OUT_DW = ((EVT_W + 7) / 8) * 8;

  // command from front to back: push an event, or pop one result
  typedef struct packed {
    logic pop;
    evt_t evt;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SLOT,
    F_REPEAT,
    F_POP
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_READ
  } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/key_press_autorepeat_queue.sv -----
// key_press_autorepeat_queue: keyboard typematic repeat with an event ring
// usage:
//   in_*  : one keyboard scan per transaction (six key slots, held count,
//           fn/ctrl/alt/shift, millisecond timestamp), accepted when
//           in_tvalid and in_tready are high
//   out_* : one result per scan; out_tuser is 1 when an event was popped,
//           0 when the ring was empty (then out_tdata is all zero)
//   cfg_* : apb-style port, 0x0 initial delay, 0x4 repeat interval (16 bit)
// scan handling: a scan with n held keys (n clamped to 6) keeps the front
//   sequencer busy through one step per key slot plus the end of the slot
//   walk, a repeat check, a pop and the accept step; a full command queue
//   stalls a push or pop, and no new scan is taken before its pop is queued
// result path: a pop passes the command queue; on an empty ring the result
//   register loads zero as the back takes the pop, else after the ram read
// a stalled receiver holds the result; the front keeps scanning until the
//   four-entry command queue fills, then in_tready stays low
// reset: ring empty, no repeating key, delay 450 ms, interval 65 ms; there is
//   no clearing pass
// depends on kpaq_pkg, kpaq_front, kpaq_cmdq, kpaq_back, kpaq_ram
`default_nettype none
module key_press_autorepeat_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  // [47:0] key_slot_0..5, [50:48] held_count, [51] fn_held, [52] ctrl_held,
  // [53] alt_held, [54] shift_held, [86:55] now_ms, [87] zero
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [kpaq_pkg::IN_DW-1:0]    in_tdata,
  // [7:0] event_key, [8] event_fn, [9] event_ctrl, [10] event_alt,
  // [11] event_shift, [12] event_repeat, [15:13] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [kpaq_pkg::OUT_DW-1:0]   out_tdata,
  // [0] event_valid
  output logic                          out_tuser,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [kpaq_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [kpaq_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [kpaq_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import kpaq_pkg::*;

  logic [CFG_W-1:0] init_delay_r;
  logic [CFG_W-1:0] repeat_ival_r;
  logic             cfg_wr;
  logic             cmd_valid_f, cmd_ready_f, cmd_valid_b, cmd_ready_b;
  cmd_t             cmd_f, cmd_b;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_delay_r  <= INIT_DELAY_RST;
      repeat_ival_r <= REPEAT_IVAL_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_INIT_DELAY:  init_delay_r  <= cfg_pwdata[CFG_W-1:0];
        REG_REPEAT_IVAL: repeat_ival_r <= cfg_pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_paddr[2])
      REG_INIT_DELAY:  cfg_prdata = CFG_DW'(init_delay_r);
      REG_REPEAT_IVAL: cfg_prdata = CFG_DW'(repeat_ival_r);
      default:         cfg_prdata = '0;
    endcase
  end

  kpaq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .init_delay  (init_delay_r),
    .repeat_ival (repeat_ival_r),
    .cmd_valid   (cmd_valid_f),
    .cmd_ready   (cmd_ready_f),
    .cmd         (cmd_f)
  );

  kpaq_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd_valid_f),
    .in_ready  (cmd_ready_f),
    .in_cmd    (cmd_f),
    .out_valid (cmd_valid_b),
    .out_ready (cmd_ready_b),
    .out_cmd   (cmd_b)
  );

  kpaq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid_b),
    .cmd_ready  (cmd_ready_b),
    .cmd        (cmd_b),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ----- rtl/kpaq_ram.sv -----
// kpaq_ram: generic single write port, single read port ram with
// registered read data; no package dependency
`default_nettype none
module kpaq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/kpaq_front.sv -----
// kpaq_front: takes one key scan, walks the key slots against the prior scan,
// tracks the repeating key and its deadline, and issues push and pop commands;
// depends on kpaq_pkg
`default_nettype none
module kpaq_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [kpaq_pkg::IN_DW-1:0]   in_tdata,
  input  logic [kpaq_pkg::CFG_W-1:0]   init_delay,
  input  logic [kpaq_pkg::CFG_W-1:0]   repeat_ival,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output kpaq_pkg::cmd_t               cmd
);
  import kpaq_pkg::*;

  front_state_t        state_r, state_nxt;
  logic [KEY_CW-1:0]   idx_r, idx_nxt;
  logic [KEY_W-1:0]    rk_r, rk_nxt;
  logic [NOW_W-1:0]    dl_r, dl_nxt;
  logic [KEY_CW-1:0]   prior_count_r;
  logic                prior_fn_r;
  logic [KEY_W-1:0]    prior_keys_r [MAX_KEYS];

  logic [KEY_W-1:0]    keys_r [MAX_KEYS];
  logic [KEY_CW-1:0]   count_r;
  mods_t               mods_r;
  logic [NOW_W-1:0]    now_r;

  logic [CNT_W-1:0]    held_count;
  logic [KEY_W-1:0]    cur_key;
  logic                was, fresh, held, fire;
  logic [KEY_W-1:0]    rk_eff;
  logic [NOW_W-1:0]    diff;
  logic                commit_prior;

  assign held_count = in_tdata[CNT_LSB +: CNT_W];
  assign cur_key    = keys_r[idx_r[KEY_IW-1:0]];

  // slot classification and repeat check
  always_comb begin
    was  = 1'b0;
    held = 1'b0;
    for (int j = 0; j < MAX_KEYS; j++) begin
      if ((KEY_CW'(j) < prior_count_r) && (prior_keys_r[j] == cur_key)) begin
        was = 1'b1;
      end
      if ((KEY_CW'(j) < count_r) && (keys_r[j] == rk_r)) begin
        held = 1'b1;
      end
    end
    fresh  = !was || (prior_fn_r != mods_r.fn);
    rk_eff = held ? rk_r : '0;
    diff   = now_r - dl_r;
    fire   = (rk_eff != '0) && !diff[NOW_W-1];
  end

  // sequencer: slots, repeat, pop
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    rk_nxt       = rk_r;
    dl_nxt       = dl_r;
    in_tready    = 1'b0;
    cmd_valid    = 1'b0;
    cmd          = '0;
    commit_prior = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          idx_nxt   = '0;
          state_nxt = F_SLOT;
        end
      end
      F_SLOT: begin
        if (idx_r < count_r) begin
          if (fresh) begin
            cmd_valid     = 1'b1;
            cmd.evt.key   = cur_key;
            cmd.evt.mods  = mods_r;
            if (cmd_ready) begin
              rk_nxt  = cur_key;
              dl_nxt  = now_r + NOW_W'(init_delay);
              idx_nxt = idx_r + KEY_CW'(1);
            end
          end else begin
            idx_nxt = idx_r + KEY_CW'(1);
          end
        end else begin
          state_nxt = F_REPEAT;
        end
      end
      F_REPEAT: begin
        if (fire) begin
          cmd_valid    = 1'b1;
          cmd.evt.key  = rk_eff;
          cmd.evt.mods = mods_r;
          cmd.evt.rep  = 1'b1;
        end
        if (!fire || cmd_ready) begin
          rk_nxt    = rk_eff;
          state_nxt = F_POP;
          if (fire) begin
            dl_nxt = now_r + NOW_W'(repeat_ival);
          end
        end
      end
      F_POP: begin
        cmd_valid = 1'b1;
        cmd.pop   = 1'b1;
        if (cmd_ready) begin
          commit_prior = 1'b1;
          state_nxt    = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= F_IDLE;
      idx_r         <= '0;
      rk_r          <= '0;
      dl_r          <= '0;
      prior_count_r <= '0;
      prior_fn_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      rk_r    <= rk_nxt;
      dl_r    <= dl_nxt;
      if (commit_prior) begin
        prior_count_r <= count_r;
        prior_fn_r    <= mods_r.fn;
      end
    end
  end

  // scan capture and prior key copy
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      for (int i = 0; i < MAX_KEYS; i++) begin
        keys_r[i] <= in_tdata[i*KEY_W +: KEY_W];
      end
      count_r      <= (held_count > CNT_W'(MAX_KEYS)) ? KEY_CW'(MAX_KEYS)
                                                      : KEY_CW'(held_count);
      mods_r.fn    <= in_tdata[FN_BIT];
      mods_r.ctrl  <= in_tdata[CTRL_BIT];
      mods_r.alt   <= in_tdata[ALT_BIT];
      mods_r.shift <= in_tdata[SHIFT_BIT];
      now_r        <= in_tdata[NOW_LSB +: NOW_W];
    end
    if (commit_prior) begin
      for (int i = 0; i < MAX_KEYS; i++) begin
        prior_keys_r[i] <= keys_r[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/kpaq_cmdq.sv -----
// kpaq_cmdq: short command queue between the scan front and the ring back;
// depends on kpaq_pkg
`default_nettype none
module kpaq_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kpaq_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output kpaq_pkg::cmd_t out_cmd
);
  import kpaq_pkg::*;

  cmd_t             slot_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CQ_CW-1:0] count_r;
  logic             wr, rd;

  assign in_ready  = (count_r != CQ_CW'(CQ_DEPTH));
  assign out_valid = (count_r != '0);
  assign out_cmd   = slot_r[rd_ptr_r];
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= (wr_ptr_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + CQ_AW'(1);
      end
      if (rd) begin
        rd_ptr_r <= (rd_ptr_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + CQ_AW'(1);
      end
      if (wr && !rd) begin
        count_r <= count_r + CQ_CW'(1);
      end else if (rd && !wr) begin
        count_r <= count_r - CQ_CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wr_ptr_r] <= in_cmd;
    end
  end

  a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> (count_r == $past(count_r) + CQ_CW'(1)))
    else $error("command queue count did not follow a write");

endmodule
`default_nettype wire

// ----- rtl/kpaq_back.sv -----
// kpaq_back: executes push and pop commands on the event ring and holds the
// result in an output register; depends on kpaq_pkg and kpaq_ram
`default_nettype none
module kpaq_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  kpaq_pkg::cmd_t              cmd,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [kpaq_pkg::OUT_DW-1:0] out_tdata,
  output logic                        out_tuser
);
  import kpaq_pkg::*;

  back_state_t        state_r, state_nxt;
  logic [RING_AW-1:0] head_r, tail_r;
  logic [RING_AW-1:0] head_inc, tail_inc;
  logic               out_valid_r, out_valid_nxt;
  evt_t               out_evt_r;
  logic               out_hit_r;
  logic               out_free, take, empty, full;
  logic               ram_we, ram_re, load_zero, load_ram;
  logic [EVT_W-1:0]   ram_rdata;

  // ring pointers and command decode
  always_comb begin
    head_inc  = (head_r == RING_AW'(RING_DEPTH - 1)) ? '0 : head_r + RING_AW'(1);
    tail_inc  = (tail_r == RING_AW'(RING_DEPTH - 1)) ? '0 : tail_r + RING_AW'(1);
    empty     = (head_r == tail_r);
    full      = (tail_inc == head_r);
    out_free  = !out_valid_r || out_tready;
    cmd_ready = (state_r == B_IDLE) && (!cmd.pop || out_free);
    take      = cmd_valid && cmd_ready;
    ram_we    = take && !cmd.pop && !full;
    ram_re    = take && cmd.pop && !empty;
    load_zero = take && cmd.pop && empty;
    load_ram  = (state_r == B_READ);
  end

  // read sequencing and output register control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (ram_re) begin
          state_nxt = B_READ;
        end
      end
      B_READ: begin
        state_nxt = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    if (load_zero || load_ram) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        tail_r <= tail_inc;
      end
      if (ram_re) begin
        head_r <= head_inc;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_zero) begin
      out_evt_r <= '0;
      out_hit_r <= 1'b0;
    end else if (load_ram) begin
      out_evt_r <= evt_t'(ram_rdata);
      out_hit_r <= 1'b1;
    end
  end

  kpaq_ram #(
    .WIDTH (EVT_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (EVT_W'(cmd.evt)),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_evt_r);
  assign out_tuser  = out_hit_r;

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_READ) |-> !out_valid_r)
    else $error("ring read returned while the output register was occupied");

  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_READ) |=> out_valid_r)
    else $error("ring read data was not presented");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !cmd.pop && full) |=> ($stable(tail_r) && $stable(head_r)))
    else $error("push into a full ring moved a pointer");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// testbench for key_press_autorepeat_queue: keyboard scans go in over the input
// stream, a local typematic model predicts every popped event and each result is checked
// depends on kpaq_pkg and the key_press_autorepeat_queue rtl
module testbench;
  import kpaq_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RING_ROOM      = RING_DEPTH - 1;
  localparam int MAX_LOGGED     = 100;

  // one keyboard scan, laid out as in in_tdata
  typedef struct packed {
    logic [NOW_W-1:0]               now;
    mods_t                          mods;
    logic [CNT_W-1:0]               count;
    logic [MAX_KEYS-1:0][KEY_W-1:0] keys;
  } scan_t;

  typedef struct packed {
    logic valid;
    evt_t evt;
  } result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic                out_tuser;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  key_press_autorepeat_queue DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // typematic model state
  logic [KEY_W-1:0]  last_keys [MAX_KEYS] = '{default: '0};
  int                last_count = 0;
  logic              last_fn = 1'b0;
  logic [KEY_W-1:0]  rep_key = '0;
  logic [NOW_W-1:0]  rep_deadline = '0;
  logic [CFG_W-1:0]  delay_ms = 16'd450;
  logic [CFG_W-1:0]  interval_ms = 16'd65;
  evt_t              ring_model [$];
  result_t           due_results [$];

  // stimulus state and knobs
  logic [KEY_W-1:0]  held [$];
  mods_t             cur_mods = '0;
  logic [NOW_W-1:0]  clock_ms = '0;
  int                tx_gap_pct = 0;
  int                rx_stall_pct = 0;
  int                rx_hold = 0;

  // counters
  int mismatches = 0;
  int results_seen = 0;
  int scans_sent = 0;
  int events_popped = 0;
  int repeats_popped = 0;
  int empty_pops = 0;
  int events_dropped = 0;
  int timing_settings = 0;
  int stall_cycles = 0;

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    // keep the log short when many results go wrong
    if (mismatches <= MAX_LOGGED)
      $display("%0t: result %0d %s: got %0h, expected %0h", $time, results_seen, what,
               got, want);
  endtask

  // ring push, dropped when the ring holds its maximum
  task automatic ring_push(input logic [KEY_W-1:0] key, input mods_t mods, input logic rep);
    evt_t e;
    e.key  = key;
    e.mods = mods;
    e.rep  = rep;
    if (ring_model.size() >= RING_ROOM) events_dropped++;
    else ring_model.push_back(e);
  endtask

  // compare a scan with the previous one, raise events, pop one result
  task automatic typematic_predict(input scan_t s);
    int n;
    logic was;
    logic still_held;
    logic [NOW_W-1:0] elapsed;
    result_t r;
    n = (s.count > MAX_KEYS) ? MAX_KEYS : s.count;
    for (int i = 0; i < n; i++) begin
      was = 1'b0;
      for (int j = 0; j < last_count; j++)
        if (last_keys[j] == s.keys[i]) was = 1'b1;
      if (!was || last_fn != s.mods.fn) begin
        ring_push(s.keys[i], s.mods, 1'b0);
        rep_key = s.keys[i];
        rep_deadline = s.now + NOW_W'(delay_ms);
      end
    end
    still_held = 1'b0;
    for (int i = 0; i < n; i++)
      if (s.keys[i] == rep_key) still_held = 1'b1;
    if (!still_held) rep_key = '0;
    // deadline reached when the wrapped difference is not negative
    elapsed = s.now - rep_deadline;
    if (rep_key != '0 && !elapsed[NOW_W-1]) begin
      ring_push(rep_key, s.mods, 1'b1);
      rep_deadline = s.now + NOW_W'(interval_ms);
    end
    for (int i = 0; i < n; i++) last_keys[i] = s.keys[i];
    last_count = n;
    last_fn = s.mods.fn;
    r = '0;
    if (ring_model.size() != 0) begin
      r.valid = 1'b1;
      r.evt = ring_model.pop_front();
    end
    due_results.push_back(r);
  endtask

  // one scan transaction, with an optional gap before it
  task automatic send_scan(input scan_t s);
    int n;
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      n = gap_len();
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DW - $bits(scan_t)){1'b0}}, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    typematic_predict(s);
    scans_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= {{(CFG_DW - CFG_W){1'b0}}, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (reg_idx == REG_INIT_DELAY) delay_ms = value;
    else interval_ms = value;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic cfg_check(input logic reg_idx, input logic [CFG_W-1:0] want);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {reg_idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {{(CFG_DW - CFG_W){1'b0}}, want})
      report_mismatch("register readback", cfg_prdata, 32'(want));
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // change both timings with the block idle, then read them back
  task automatic set_timing(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] interval);
    wait_drained();
    cfg_write(REG_INIT_DELAY, delay);
    cfg_write(REG_REPEAT_IVAL, interval);
    cfg_check(REG_INIT_DELAY, delay);
    cfg_check(REG_REPEAT_IVAL, interval);
    timing_settings++;
  endtask

  function automatic scan_t mk_scan(input logic [47:0] keys, input logic [CNT_W-1:0] cnt,
                                    input mods_t m, input logic [NOW_W-1:0] now);
    scan_t s;
    s.keys  = keys;
    s.count = cnt;
    s.mods  = m;
    s.now   = now;
    return s;
  endfunction

  // scan from the currently held keys; unused slots carry junk
  function automatic scan_t held_scan();
    scan_t s;
    for (int i = 0; i < MAX_KEYS; i++)
      s.keys[i] = (i < held.size()) ? held[i] : KEY_W'($urandom_range(0, 255));
    s.count = CNT_W'(held.size());
    // count above six clamps
    if (held.size() == MAX_KEYS && $urandom_range(0, 4) == 0) s.count = '1;
    s.mods = cur_mods;
    s.now = clock_ms;
    return s;
  endfunction

  // realistic typing: a small key pool, slowly changing held set, advancing time
  task automatic run_session(input int n_scans);
    logic [KEY_W-1:0] pool [8];
    int change_pct;
    int r;
    foreach (pool[i])
      pool[i] = ($urandom_range(0, 15) == 0) ? 8'h00 : KEY_W'($urandom_range(1, 255));
    change_pct = $urandom_range(5, 40);
    held.delete();
    repeat (n_scans) begin
      if ($urandom_range(0, 99) < change_pct) begin
        if ((held.size() < MAX_KEYS && $urandom_range(0, 2) != 0) || held.size() == 0)
          held.push_back(pool[$urandom_range(0, 7)]);
        else
          held.delete($urandom_range(0, held.size() - 1));
      end
      if ($urandom_range(0, 9) == 0) cur_mods.ctrl = ~cur_mods.ctrl;
      if ($urandom_range(0, 9) == 0) cur_mods.alt = ~cur_mods.alt;
      if ($urandom_range(0, 9) == 0) cur_mods.shift = ~cur_mods.shift;
      if ($urandom_range(0, 39) == 0) cur_mods.fn = ~cur_mods.fn;
      r = $urandom_range(0, 99);
      if (r < 88) clock_ms += $urandom_range(0, 30);
      else if (r < 98) clock_ms += $urandom_range(31, 700);
      else clock_ms += $urandom;
      send_scan(held_scan());
    end
  endtask

  // fully random scan, timestamp included
  task automatic send_noise();
    logic [95:0] raw;
    scan_t s;
    raw = {$urandom, $urandom, $urandom};
    s = raw[$bits(scan_t)-1:0];
    clock_ms = s.now;
    send_scan(s);
  endtask

  task automatic test_register_defaults();
    cfg_check(REG_INIT_DELAY, delay_ms);
    cfg_check(REG_REPEAT_IVAL, interval_ms);
  endtask

  // hand-picked scans under the reset timing
  task automatic test_directed_scans();
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    // nothing held: empty pop
    send_scan(mk_scan(48'h0, 3'd0, 4'b0000, 32'd1000));
    // key code zero presses but never repeats
    send_scan(mk_scan(48'h00, 3'd1, 4'b0000, 32'd1010));
    // two new keys in slot order, last one repeats
    send_scan(mk_scan(48'h01FF, 3'd2, 4'b1110, 32'd1020));
    send_scan(mk_scan(48'h01FF, 3'd2, 4'b1110, 32'd1470));
    send_scan(mk_scan(48'h01FF, 3'd2, 4'b1110, 32'd1535));
    // fn change re-presses every held key
    send_scan(mk_scan(48'h01FF, 3'd2, 4'b1111, 32'd1540));
    // count of seven clamps to six slots
    send_scan(mk_scan(48'h804020100804, 3'd7, 4'b1111, 32'd1541));
    send_scan(mk_scan(48'h804020100804, 3'd7, 4'b0001, 32'd1542));
    // alternating full sets overflow the ring
    send_scan(mk_scan(48'h0C0B0A090807, 3'd6, 4'b0000, 32'd2000));
    send_scan(mk_scan(48'h161514131211, 3'd6, 4'b0000, 32'd2001));
    send_scan(mk_scan(48'h0C0B0A090807, 3'd6, 4'b0000, 32'd2002));
    send_scan(mk_scan(48'h161514131211, 3'd6, 4'b0000, 32'd2003));
    send_scan(mk_scan(48'h0C0B0A090807, 3'd6, 4'b0000, 32'd2004));
    // duplicate codes in two slots
    send_scan(mk_scan(48'h3333, 3'd2, 4'b0100, 32'd2010));
    // deadline across the timestamp wrap
    send_scan(mk_scan(48'h55, 3'd1, 4'b1000, 32'hFFFF_FF00));
    send_scan(mk_scan(48'h55, 3'd1, 4'b1000, 32'hFFFF_FFF0));
    send_scan(mk_scan(48'h55, 3'd1, 4'b1000, 32'h0000_00D0));
    send_scan(mk_scan(48'hAA55, 3'd2, 4'b0010, 32'h0000_00D1));
    // all released
    send_scan(mk_scan(48'h0, 3'd0, 4'b0000, 32'h0000_00D2));
  endtask

  task automatic test_timing_extremes();
    int delays [6] = '{0, 0, 65535, 1, 65535, 450};
    int intervals [6] = '{0, 1, 65535, 65535, 0, 65};
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    clock_ms = $urandom;
    foreach (delays[i]) begin
      set_timing(CFG_W'(delays[i]), CFG_W'(intervals[i]));
      run_session(25);
    end
  endtask

  task automatic test_random_traffic();
    int phase_sent;
    int n;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          tx_gap_pct = 0;
          rx_stall_pct = 0;
        end
        3: begin
          tx_gap_pct = 60;
          rx_stall_pct = 60;
        end
        default: begin
          tx_gap_pct = $urandom_range(10, 40);
          rx_stall_pct = $urandom_range(10, 40);
        end
      endcase
      set_timing(($urandom_range(0, 3) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 200)),
                 ($urandom_range(0, 3) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 80)));
      phase_sent = 0;
      while (phase_sent < 265) begin
        if ($urandom_range(0, 99) < 12) begin
          send_noise();
          phase_sent++;
        end else begin
          n = $urandom_range(8, 40);
          run_session(n);
          phase_sent += n;
        end
        // sender holds off until the ring output catches up
        if (phase == 2 && phase_sent > 130 && phase_sent < 170) wait_drained();
      end
    end
  endtask

  // result transactions checked against the oldest prediction
  always @(posedge clk) begin : check_result
    result_t want;
    evt_t got;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got = out_tdata[EVT_W-1:0];
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_tdata), 32'd0);
      end else begin
        want = due_results.pop_front();
        if (out_tuser !== want.valid)
          report_mismatch("event_valid", 32'(out_tuser), 32'(want.valid));
        if (got.key !== want.evt.key)
          report_mismatch("event_key", 32'(got.key), 32'(want.evt.key));
        if (got.mods.fn !== want.evt.mods.fn)
          report_mismatch("event_fn", 32'(got.mods.fn), 32'(want.evt.mods.fn));
        if (got.mods.ctrl !== want.evt.mods.ctrl)
          report_mismatch("event_ctrl", 32'(got.mods.ctrl), 32'(want.evt.mods.ctrl));
        if (got.mods.alt !== want.evt.mods.alt)
          report_mismatch("event_alt", 32'(got.mods.alt), 32'(want.evt.mods.alt));
        if (got.mods.shift !== want.evt.mods.shift)
          report_mismatch("event_shift", 32'(got.mods.shift), 32'(want.evt.mods.shift));
        if (got.rep !== want.evt.rep)
          report_mismatch("event_repeat", 32'(got.rep), 32'(want.evt.rep));
        if (want.valid) begin
          events_popped++;
          if (want.evt.rep) repeats_popped++;
        end else begin
          empty_pops++;
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin : drive_out_ready
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      rx_hold = gap_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // stop a hung run
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_defaults();
    test_directed_scans();
    test_timing_extremes();
    test_random_traffic();

    wait_drained();
    $display("covered %0d scans: %0d events popped (%0d repeats), %0d empty pops",
             scans_sent, events_popped, repeats_popped, empty_pops);
    $display("ring overflow dropped %0d events; %0d timing settings applied",
             events_dropped, timing_settings);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
